[rtl/cubic_bezier_easing_assert.svh]
// Assertion macros for the cubic Bezier easing block.
// Used by the checker; needs clk and arst_n in scope.
`ifndef CUBIC_BEZIER_EASING_ASSERT_SVH
`define CUBIC_BEZIER_EASING_ASSERT_SVH

// same-cycle implication
`define CBE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define CBE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[rtl/cbe_pkg.sv]
// Shared types and constants for the cubic Bezier easing block.
// No dependencies.
package cbe_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ITER      = 8;
	localparam int ITER_W    = $clog2(ITER + 1);
	localparam int DIV_STEPS = 17;
	localparam int DIV_W     = $clog2(DIV_STEPS);

	localparam logic [16:0]        ONE  = 17'd65536;
	localparam logic signed [41:0] HALF = 42'sd32768;

	localparam logic [2:0] REG_X1  = 3'd0;
	localparam logic [2:0] REG_Y1  = 3'd1;
	localparam logic [2:0] REG_X2  = 3'd2;
	localparam logic [2:0] REG_Y2  = 3'd3;
	localparam logic [2:0] REG_TOL = 3'd4;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_UU, OP_TT, OP_UT, OP_B1, OP_B2, OP_B3,
		OP_A1, OP_A2, OP_BEZ, OP_S1, OP_S2, OP_S3, OP_SLP,
		OP_DINIT, OP_DSTEP, OP_UPD, OP_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic sel_y;
	} cmd_t;

	typedef struct packed {
		logic at_end;
		logic close;
		logic dzero;
	} sts_t;

	typedef struct packed {
		logic [16:0] x1;
		logic [18:0] y1;
		logic [16:0] x2;
		logic [18:0] y2;
		logic [15:0] tol;
	} cfg_t;

endpackage

[rtl/cbe_datapath.sv]
// Datapath: one shared multiplier, accumulator, serial divider, Newton update.
// Depends on cbe_pkg.
module cbe_datapath import cbe_pkg::*; (
	input  logic               clk,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	input  logic [16:0]        progress,
	output sts_t               sts,
	output logic signed [18:0] eased
);

	logic [16:0] x_q, t_q, uu_q, tt_q, ut_q, b1_q, b2_q, b3_q;
	logic signed [41:0] acc_q;
	logic signed [21:0] f_q, dx_q, d_q;
	logic [21:0] rem_q, den_q;
	logic [16:0] nlo_q;
	logic [16:0] quo_q;
	logic qneg_q, sat_q;
	logic signed [18:0] eased_q;

	logic [16:0] u;
	logic [18:0] uu3, tt3;
	logic [19:0] ut6;
	logic signed [19:0] p1, p2, dp, omx2, mul_a, mul_b;
	logic signed [39:0] prod;
	logic signed [41:0] prod_ext, rnd_full, bez_full, slp_full;
	logic signed [21:0] dx_new;
	logic [21:0] adx, aden;
	logic [22:0] trial;
	logic ge;
	logic [17:0] qmag;
	logic signed [18:0] qs;
	logic signed [19:0] tn;

	always_comb begin
		u    = ONE - t_q;
		uu3  = {2'b0, uu_q} + {1'b0, uu_q, 1'b0};
		tt3  = {2'b0, tt_q} + {1'b0, tt_q, 1'b0};
		ut6  = {1'b0, ut_q, 2'b0} + {2'b0, ut_q, 1'b0};
		p1   = cmd.sel_y ? $signed({cfg.y1[18], cfg.y1}) : $signed({3'b0, cfg.x1});
		p2   = cmd.sel_y ? $signed({cfg.y2[18], cfg.y2}) : $signed({3'b0, cfg.x2});
		dp   = $signed({3'b0, cfg.x2}) - $signed({3'b0, cfg.x1});
		omx2 = $signed({3'b0, ONE}) - $signed({3'b0, cfg.x2});
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_UU: begin mul_a = $signed({3'b0, u});    mul_b = $signed({3'b0, u});    end
			OP_TT: begin mul_a = $signed({3'b0, t_q});  mul_b = $signed({3'b0, t_q});  end
			OP_UT: begin mul_a = $signed({3'b0, u});    mul_b = $signed({3'b0, t_q});  end
			OP_B1: begin mul_a = $signed({1'b0, uu3});  mul_b = $signed({3'b0, t_q});  end
			OP_B2: begin mul_a = $signed({1'b0, tt3});  mul_b = $signed({3'b0, u});    end
			OP_B3: begin mul_a = $signed({3'b0, tt_q}); mul_b = $signed({3'b0, t_q});  end
			OP_A1: begin mul_a = $signed({3'b0, b1_q}); mul_b = p1;                    end
			OP_A2: begin mul_a = $signed({3'b0, b2_q}); mul_b = p2;                    end
			OP_S1: begin mul_a = $signed({1'b0, uu3});  mul_b = $signed({3'b0, cfg.x1}); end
			OP_S2: begin mul_a = $signed(ut6);          mul_b = dp;                    end
			OP_S3: begin mul_a = $signed({1'b0, tt3});  mul_b = omx2;                  end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		prod     = mul_a * mul_b;
		prod_ext = {{2{prod[39]}}, prod};
		rnd_full = (prod_ext + HALF) >>> FRAC_BITS;
		bez_full = (acc_q + $signed({9'b0, b3_q, 16'b0}) + HALF) >>> FRAC_BITS;
		slp_full = (acc_q + HALF) >>> FRAC_BITS;
		dx_new   = bez_full[21:0] - $signed({5'b0, x_q});
		adx      = dx_q[21] ? 22'(-dx_q) : 22'(dx_q);
		aden     = d_q[21] ? 22'(-d_q) : 22'(d_q);
		trial    = {rem_q, nlo_q[16]};
		ge       = trial >= {1'b0, den_q};
		qmag     = sat_q ? 18'd131072 : {1'b0, quo_q};
		qs       = qneg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		tn       = $signed({3'b0, t_q}) - $signed({qs[18], qs});
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				x_q <= progress;
				t_q <= progress;
			end
			OP_UU: uu_q <= rnd_full[16:0];
			OP_TT: tt_q <= rnd_full[16:0];
			OP_UT: ut_q <= rnd_full[16:0];
			OP_B1: b1_q <= rnd_full[16:0];
			OP_B2: b2_q <= rnd_full[16:0];
			OP_B3: b3_q <= rnd_full[16:0];
			OP_A1, OP_S1: acc_q <= prod_ext;
			OP_A2, OP_S2, OP_S3: acc_q <= acc_q + prod_ext;
			OP_BEZ: begin
				f_q  <= bez_full[21:0];
				dx_q <= dx_new;
			end
			OP_SLP: d_q <= slp_full[21:0];
			OP_DINIT: begin
				rem_q  <= {1'b0, adx[21:1]};
				nlo_q  <= {adx[0], 16'b0};
				den_q  <= aden;
				qneg_q <= dx_q[21] ^ d_q[21];
				sat_q  <= {1'b0, adx[21:1]} >= aden;
				quo_q  <= '0;
			end
			OP_DSTEP: begin
				rem_q <= ge ? 22'(trial - {1'b0, den_q}) : trial[21:0];
				nlo_q <= {nlo_q[15:0], 1'b0};
				quo_q <= {quo_q[15:0], ge};
			end
			OP_UPD: begin
				if (tn < 0)
					t_q <= '0;
				else if (tn > $signed({3'b0, ONE}))
					t_q <= ONE;
				else
					t_q <= tn[16:0];
			end
			OP_OUT: begin
				if (x_q == '0)
					eased_q <= '0;
				else if (x_q >= ONE)
					eased_q <= $signed({2'b0, ONE});
				else if (f_q > 22'sd131072)
					eased_q <= 19'sd131072;
				else if (f_q < -22'sd131072)
					eased_q <= -19'sd131072;
				else
					eased_q <= f_q[18:0];
			end
			default: ;
		endcase
	end

	assign sts.at_end = (x_q == '0) || (x_q >= ONE);
	assign sts.close  = adx < {6'b0, cfg.tol};
	assign sts.dzero  = (d_q == '0);
	assign eased      = eased_q;

endmodule

[rtl/cbe_ctrl.sv]
// Controller: sequences the Newton steps and final y evaluation, owns handshakes.
// Depends on cbe_pkg.
module cbe_ctrl import cbe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_UU, S_TT, S_UT, S_B1, S_B2, S_B3, S_A1, S_A2, S_BEZ, S_CHK,
		S_S1, S_S2, S_S3, S_SLP, S_ZCHK, S_DINIT, S_DSTEP, S_UPD,
		S_FUU, S_FTT, S_FB1, S_FB2, S_FB3, S_FA1, S_FA2, S_FBEZ, S_OUT
	} state_t;

	state_t state_q;
	logic [ITER_W-1:0] iter_q;
	logic [DIV_W-1:0] div_q;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.sel_y = 1'b0;
		unique case (state_q)
			S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_UU, S_FUU: cmd.op = OP_UU;
			S_TT, S_FTT: cmd.op = OP_TT;
			S_UT:    cmd.op = OP_UT;
			S_B1, S_FB1: cmd.op = OP_B1;
			S_B2, S_FB2: cmd.op = OP_B2;
			S_B3, S_FB3: cmd.op = OP_B3;
			S_A1, S_FA1: cmd.op = OP_A1;
			S_A2, S_FA2: cmd.op = OP_A2;
			S_BEZ, S_FBEZ: cmd.op = OP_BEZ;
			S_S1:    cmd.op = OP_S1;
			S_S2:    cmd.op = OP_S2;
			S_S3:    cmd.op = OP_S3;
			S_SLP:   cmd.op = OP_SLP;
			S_DINIT: cmd.op = OP_DINIT;
			S_DSTEP: cmd.op = OP_DSTEP;
			S_UPD:   cmd.op = OP_UPD;
			S_OUT:   cmd.op = out_free ? OP_OUT : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
		if (state_q == S_FA1 || state_q == S_FA2 || state_q == S_FBEZ)
			cmd.sel_y = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iter_q      <= '0;
			div_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_START;
				S_START: begin
					iter_q  <= '0;
					state_q <= sts.at_end ? S_OUT : S_UU;
				end
				S_UU:  state_q <= S_TT;
				S_TT:  state_q <= S_UT;
				S_UT:  state_q <= S_B1;
				S_B1:  state_q <= S_B2;
				S_B2:  state_q <= S_B3;
				S_B3:  state_q <= S_A1;
				S_A1:  state_q <= S_A2;
				S_A2:  state_q <= S_BEZ;
				S_BEZ: state_q <= S_CHK;
				S_CHK: state_q <= sts.close ? S_FUU : S_S1;
				S_S1:  state_q <= S_S2;
				S_S2:  state_q <= S_S3;
				S_S3:  state_q <= S_SLP;
				S_SLP: state_q <= S_ZCHK;
				S_ZCHK: state_q <= sts.dzero ? S_FUU : S_DINIT;
				S_DINIT: begin
					div_q   <= '0;
					state_q <= S_DSTEP;
				end
				S_DSTEP: begin
					div_q <= div_q + 1'b1;
					if (div_q == DIV_W'(DIV_STEPS - 1))
						state_q <= S_UPD;
				end
				S_UPD: begin
					iter_q  <= iter_q + 1'b1;
					state_q <= (iter_q == ITER_W'(ITER - 1)) ? S_FUU : S_UU;
				end
				S_FUU:  state_q <= S_FTT;
				S_FTT:  state_q <= S_FB1;
				S_FB1:  state_q <= S_FB2;
				S_FB2:  state_q <= S_FB3;
				S_FB3:  state_q <= S_FA1;
				S_FA1:  state_q <= S_FA2;
				S_FA2:  state_q <= S_FBEZ;
				S_FBEZ: state_q <= S_OUT;
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/cubic_bezier_easing.sv]
// Top level of the cubic Bezier easing block: config registers, controller, datapath.
// Depends on cbe_pkg, cbe_ctrl, cbe_datapath.
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    progress[16:0]
//  out      out  out_valid/out_stall  eased[18:0] signed
//  cfg      in   cfg_we               cfg_index[2:0], cfg_data[18:0]
//
// One beat in, one beat out. Input 0 or >= 1.0 goes from start straight to output;
// otherwise each Newton step runs the curve and slope on the shared multiplier, the
// tolerance and zero-slope checks, the serial divide and the update, up to 8 steps,
// then the final y evaluation, with accept, start and output states around them.
// A new beat is taken in while the previous result waits on out_stall; the output
// state waits while that result is still stalled.
// Reset restores the control-point defaults; no clearing pass.
module cubic_bezier_easing import cbe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [16:0]        progress,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [18:0] eased,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [18:0]        cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x1  <= 17'd27525;
			cfg_q.y1  <= 19'd0;
			cfg_q.x2  <= 17'd38011;
			cfg_q.y2  <= 19'd65536;
			cfg_q.tol <= 16'd7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X1:  cfg_q.x1  <= cfg_data[16:0];
				REG_Y1:  cfg_q.y1  <= cfg_data;
				REG_X2:  cfg_q.x2  <= cfg_data[16:0];
				REG_Y2:  cfg_q.y2  <= cfg_data;
				REG_TOL: cfg_q.tol <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	cbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cbe_datapath u_dp (
		.clk      (clk),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.progress (progress),
		.sts      (sts),
		.eased    (eased)
	);

endmodule

[rtl/cbe_checker.sv]
// Port-level checks for the cubic Bezier easing block, bound to the top level.
// Depends on cubic_bezier_easing_assert.svh.
`include "cubic_bezier_easing_assert.svh"
module cbe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [18:0] eased
);

	`CBE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted beat did not busy the block")
	`CBE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(eased), "stalled result changed")
	`CBE_ASSERT_IMPL(a_out_range, out_valid, (eased <= 19'sd131072) && (eased >= -19'sd131072), "result outside saturation range")

endmodule

bind cubic_bezier_easing cbe_checker u_cbe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.eased     (eased)
);
